// ===== sv/irds_pkg.sv =====
`default_nettype none

package irds_pkg;

    localparam int SAMPLES_PER_ITEM = 5;
    localparam int ADC_BITS         = 10;
    localparam int DIST_FRAC_BITS   = 8;

    localparam int DIST_W     = 24;
    localparam int SPEED_W    = 12;
    localparam int DEADBAND_W = 11;
    localparam int LIMIT_W    = 11;
    localparam int THRESH_W   = 8;
    localparam int COUNT_W    = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [DIST_W-1:0]     DIST_MAX           = '1;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RESET     = 11'd26;
    localparam logic [LIMIT_W-1:0]    LIMIT_RESET        = 11'd1280;
    localparam logic [THRESH_W-1:0]   THRESHOLD_RESET    = 8'd10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEADBAND  = 2'd0,
        CFG_LIMIT     = 2'd1,
        CFG_THRESHOLD = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [DEADBAND_W-1:0] deadband;
        logic [LIMIT_W-1:0]    limit;
        logic [THRESH_W-1:0]   threshold;
    } cfg_t;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    function automatic logic [63:0] log2_q30(input logic [31:0] x);
        logic [63:0] y;
        logic [63:0] acc;
        int n;
        int k;
        int i;
        n = 0;
        if (x == 32'd0) begin
            return 64'd0;
        end
        for (k = 0; k < 31; k++) begin
            if ((x >> (k + 1)) != 32'd0) begin
                n = k + 1;
            end
        end
        y = ({32'd0, x} << 30) >> n;
        acc = 64'(n) << 30;
        for (i = 29; i >= 0; i--) begin
            y = (y * y) >> 30;
            if (y >= (Q30_ONE << 1)) begin
                y = y >> 1;
                acc = acc | (64'd1 << i);
            end
        end
        return acc;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        int k;
        rem  = v;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (k = 0; k < 32; k++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [DIST_W-1:0] exp2_to_int(input longint z);
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] r;
        logic [63:0] root;
        int i;
        if (z < 0) begin
            return '0;
        end
        n = 64'(z) >> 30;
        f = 64'(z) & (Q30_ONE - 64'd1);
        if (n >= 64'd24) begin
            return DIST_MAX;
        end
        root = Q30_ONE << 1;
        r    = Q30_ONE;
        for (i = 1; i <= 30; i++) begin
            root = isqrt64(root << 30);
            if (((f >> (30 - i)) & 64'd1) != 64'd0) begin
                r = (r * root) >> 30;
            end
        end
        r = (r << n) >> 30;
        return (r > 64'(DIST_MAX)) ? DIST_MAX : r[DIST_W-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] distance_of(input logic [31:0] mv, input int frac_bits);
        longint l1000;
        longint lmv;
        longint z;
        if (mv == 32'd0) begin
            return DIST_MAX;
        end
        l1000 = longint'(log2_q30(32'd1000));
        lmv   = longint'(log2_q30(mv));
        z = ((l1000 - lmv) * 64'sd12045) / 64'sd10000;
        z = z + longint'(log2_q30(32'd27728)) - l1000;
        z = z + (longint'(frac_bits) <<< 30);
        return exp2_to_int(z);
    endfunction

endpackage

`default_nettype wire

// ===== sv/irds_if.sv =====
`default_nettype none

interface irds_item_if #(
    parameter int ADC_BITS = irds_pkg::ADC_BITS
);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] sample_0;
    logic [ADC_BITS-1:0] sample_1;
    logic [ADC_BITS-1:0] sample_2;
    logic [ADC_BITS-1:0] sample_3;
    logic [ADC_BITS-1:0] sample_4;

    modport source (
        output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
        input  ready
    );
    modport sink (
        input  valid, sample_0, sample_1, sample_2, sample_3, sample_4,
        output ready
    );
endinterface

interface irds_result_if;
    logic                                valid;
    logic                                ready;
    logic [irds_pkg::DIST_W-1:0]         distance;
    logic signed [irds_pkg::SPEED_W-1:0] speed;
    logic                                speed_updated;

    modport source (
        output valid, distance, speed, speed_updated,
        input  ready
    );
    modport sink (
        input  valid, distance, speed, speed_updated,
        output ready
    );
endinterface

interface irds_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [irds_pkg::CFG_INDEX_W-1:0] index;
    logic [irds_pkg::CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/ir_range_distance_and_speed_top.sv =====
`default_nettype none

// Channel   Dir  Payload                                  Transfer
// item      in   sample_0 .. sample_4                     item.valid & item.ready
// result    out  distance, speed, speed_updated           result.valid & result.ready
// cfg       in   index, data (deadband, limit, threshold) cfg.valid & cfg.ready
//
// One item per cycle sustained while result.ready holds; stages after the item transfer:
// lane pair sums, sum and mean, distance ROM read, speed and output register.
// The ROM has 2^ADC_BITS entries indexed by the mean; its read port sets the third stage.
// rst_n clears all valid bits, the period counter, stored distance and held speed,
// and loads the register defaults. Each stage holds while the next one is full and
// stalled, so bubbles close up; cfg is always ready.

module ir_range_distance_and_speed_top #(
    parameter int ADC_BITS       = irds_pkg::ADC_BITS,
    parameter int DIST_FRAC_BITS = irds_pkg::DIST_FRAC_BITS
) (
    input wire logic          clk,
    input wire logic          rst_n,
    irds_item_if.sink         item,
    irds_result_if.source     result,
    irds_cfg_if.sink          cfg
);

    localparam int S         = irds_pkg::SAMPLES_PER_ITEM;
    localparam int NUM_LANES = (S + 1) / 2;

    irds_pkg::cfg_t              cfg_reg;
    logic [ADC_BITS-1:0]         smp [S];
    logic [ADC_BITS:0]           lane_sum [NUM_LANES];
    logic                        s1_valid_reg;
    logic                        s1_ready;
    logic                        s2_ready;
    logic                        s2_valid;
    logic [ADC_BITS-1:0]         s2_mean;
    logic                        s3_ready;
    logic                        s3_valid;
    logic [irds_pkg::DIST_W-1:0] s3_dist;
    logic                        s1_take;

    assign smp[0] = item.sample_0;
    assign smp[1] = item.sample_1;
    assign smp[2] = item.sample_2;
    assign smp[3] = item.sample_3;
    assign smp[4] = item.sample_4;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband  <= irds_pkg::DEADBAND_RESET;
            cfg_reg.limit     <= irds_pkg::LIMIT_RESET;
            cfg_reg.threshold <= irds_pkg::THRESHOLD_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (irds_pkg::cfg_index_t'(cfg.index))
                irds_pkg::CFG_DEADBAND:  cfg_reg.deadband  <= cfg.data;
                irds_pkg::CFG_LIMIT:     cfg_reg.limit     <= cfg.data;
                irds_pkg::CFG_THRESHOLD:
                    cfg_reg.threshold <= cfg.data[irds_pkg::THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign item.ready = s1_ready;
    assign s1_take    = item.valid && s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        logic [ADC_BITS-1:0] b_in;
        if (2 * l + 1 < S)
        begin : g_pair
            assign b_in = smp[2 * l + 1];
        end
        else
        begin : g_single
            assign b_in = '0;
        end
        irds_lane #(
            .ADC_BITS (ADC_BITS)
        ) u_lane (
            .clk (clk),
            .en  (s1_take),
            .a   (smp[2 * l]),
            .b   (b_in),
            .sum (lane_sum[l])
        );
    end

    irds_merge #(
        .ADC_BITS (ADC_BITS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_ready  (s2_ready),
        .lane_sum  (lane_sum),
        .out_valid (s2_valid),
        .out_ready (s3_ready),
        .mean      (s2_mean)
    );

    logic s4_ready;

    irds_rom #(
        .ADC_BITS       (ADC_BITS),
        .DIST_FRAC_BITS (DIST_FRAC_BITS)
    ) u_rom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s3_ready),
        .mean      (s2_mean),
        .out_valid (s3_valid),
        .out_ready (s4_ready),
        .cm        (s3_dist)
    );

    irds_speed #(
        .DIST_FRAC_BITS (DIST_FRAC_BITS)
    ) u_speed (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s3_valid),
        .in_ready    (s4_ready),
        .cm          (s3_dist),
        .cfg         (cfg_reg),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .out_dist    (result.distance),
        .out_speed   (result.speed),
        .out_updated (result.speed_updated)
    );

    a_speed_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.speed_updated |->
            ($signed(result.speed) <= $signed({1'b0, cfg_reg.limit})) &&
            ($signed(result.speed) >= -$signed({1'b0, cfg_reg.limit})))
        else $error("updated speed outside clamp");

    a_item_enters_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> s1_valid_reg)
        else $error("transferred item lost at lane stage");

    a_dist_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid && s4_ready |=> result.valid)
        else $error("distance stage advanced without filling output");

endmodule

`default_nettype wire

// ===== sv/irds_lane.sv =====
`default_nettype none

module irds_lane #(
    parameter int ADC_BITS = irds_pkg::ADC_BITS
) (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [ADC_BITS-1:0] a,
    input  wire logic [ADC_BITS-1:0] b,
    output logic      [ADC_BITS:0]   sum
);

    logic [ADC_BITS:0] sum_reg;
    logic [ADC_BITS:0] sum_next;

    assign sum_next = {1'b0, a} + {1'b0, b};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

// ===== sv/irds_merge.sv =====
`default_nettype none

module irds_merge #(
    parameter int ADC_BITS = irds_pkg::ADC_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [ADC_BITS:0]   lane_sum [(irds_pkg::SAMPLES_PER_ITEM + 1) / 2],
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic      [ADC_BITS-1:0] mean
);

    localparam int NUM_LANES   = (irds_pkg::SAMPLES_PER_ITEM + 1) / 2;
    localparam int SPI_LOG     = $clog2(irds_pkg::SAMPLES_PER_ITEM);
    localparam int SUM_W       = ADC_BITS + SPI_LOG;
    localparam int RECIP_SHIFT = SUM_W + SPI_LOG + 1;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(irds_pkg::SAMPLES_PER_ITEM) - 64'd1)
                 / 64'(irds_pkg::SAMPLES_PER_ITEM));

    logic                valid_reg;
    logic [ADC_BITS-1:0] mean_reg;
    logic [ADC_BITS-1:0] mean_next;
    logic [SUM_W-1:0]    total;
    logic [PROD_W-1:0]   prod;

    always_comb
    begin
        total = '0;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            total = total + SUM_W'(lane_sum[l]);
        end
    end

    assign prod      = PROD_W'(total) * PROD_W'(RECIP);
    assign mean_next = prod[RECIP_SHIFT +: ADC_BITS];
    assign in_ready  = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mean_reg <= mean_next;
        end
    end

    assign out_valid = valid_reg;
    assign mean      = mean_reg;

endmodule

`default_nettype wire

// ===== sv/irds_rom.sv =====
`default_nettype none

module irds_rom #(
    parameter int ADC_BITS       = irds_pkg::ADC_BITS,
    parameter int DIST_FRAC_BITS = irds_pkg::DIST_FRAC_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [ADC_BITS-1:0]           mean,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [irds_pkg::DIST_W-1:0]   cm
);

    localparam int     DEPTH   = 1 << ADC_BITS;
    localparam longint ADC_MAX = longint'(DEPTH) - 1;

    typedef logic [irds_pkg::DIST_W-1:0] rom_t [DEPTH];

    function automatic rom_t build_rom();
        rom_t   t;
        longint mv;
        for (int m = 0; m < DEPTH; m++)
        begin
            mv   = (longint'(m) * 5000) / ADC_MAX;
            t[m] = irds_pkg::distance_of(32'(mv), DIST_FRAC_BITS);
        end
        return t;
    endfunction

    localparam rom_t ROM = build_rom();

    logic                        valid_reg;
    logic [irds_pkg::DIST_W-1:0] dist_reg;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            dist_reg <= ROM[mean];
        end
    end

    assign out_valid = valid_reg;
    assign cm        = dist_reg;

endmodule

`default_nettype wire

// ===== sv/irds_speed.sv =====
`default_nettype none

module irds_speed #(
    parameter int DIST_FRAC_BITS = irds_pkg::DIST_FRAC_BITS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [irds_pkg::DIST_W-1:0]          cm,
    input  wire irds_pkg::cfg_t                       cfg,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic      [irds_pkg::DIST_W-1:0]          out_dist,
    output logic signed [irds_pkg::SPEED_W-1:0]       out_speed,
    output logic                                      out_updated
);

    localparam int DW    = irds_pkg::DIST_W;
    localparam int SW    = irds_pkg::SPEED_W;
    localparam int LW    = irds_pkg::LIMIT_W;
    localparam int MAG_W = DW + 8;
    localparam int SHR   = (DIST_FRAC_BITS >= 8) ? DIST_FRAC_BITS - 8 : 0;
    localparam int SHL   = (DIST_FRAC_BITS < 8) ? 8 - DIST_FRAC_BITS : 0;

    logic                               valid_reg;
    logic [DW-1:0]                      dist_reg;
    logic signed [SW-1:0]               speed_reg;
    logic signed [SW-1:0]               speed_next;
    logic                               updated_reg;
    logic [irds_pkg::COUNT_W-1:0]       count_reg;
    logic [irds_pkg::COUNT_W-1:0]       count_next;
    logic [DW-1:0]                      stored_reg;
    logic [DW-1:0]                      stored_next;
    logic signed [SW-1:0]               held_reg;
    logic signed [SW-1:0]               held_next;
    logic                               take;
    logic                               update;
    logic                               neg;
    logic [DW-1:0]                      diff;
    logic [MAG_W-1:0]                   mag;
    logic [MAG_W-1:0]                   banded;
    logic [LW-1:0]                      clamped;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;
    assign update   = count_reg > cfg.threshold;

    always_comb
    begin
        neg    = cm < stored_reg;
        diff   = neg ? stored_reg - cm : cm - stored_reg;
        mag    = ({{(MAG_W - DW){1'b0}}, diff} << SHL) >> SHR;
        banded = (mag < MAG_W'(cfg.deadband)) ? '0 : mag;
        clamped = (banded > MAG_W'(cfg.limit)) ? cfg.limit : banded[LW-1:0];
        if (update)
        begin
            held_next   = neg ? -$signed({1'b0, clamped}) : $signed({1'b0, clamped});
            stored_next = cm;
            count_next  = '0;
        end
        else
        begin
            held_next   = held_reg;
            stored_next = stored_reg;
            count_next  = count_reg + 1'b1;
        end
        speed_next = held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            count_reg  <= '0;
            stored_reg <= '0;
            held_reg   <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (take)
            begin
                count_reg  <= count_next;
                stored_reg <= stored_next;
                held_reg   <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            dist_reg    <= cm;
            speed_reg   <= speed_next;
            updated_reg <= update;
        end
    end

    assign out_valid   = valid_reg;
    assign out_dist    = dist_reg;
    assign out_speed   = speed_reg;
    assign out_updated = updated_reg;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam logic [irds_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int ADC_TOP = (1 << irds_pkg::ADC_BITS) - 1;

    typedef struct packed {
        logic [irds_pkg::DIST_W-1:0]         cm;
        logic signed [irds_pkg::SPEED_W-1:0] speed;
        logic                                updated;
    } reading_t;

    typedef struct packed {
        logic [irds_pkg::SAMPLES_PER_ITEM-1:0][irds_pkg::ADC_BITS-1:0] adc;
        logic                                                          typed;
        reading_t                                                      want;
    } burst_t;

    logic clk = 1'b0;
    logic rst_n;

    irds_item_if   item_if ();
    irds_result_if result_if ();
    irds_cfg_if    cfg_if ();

    ir_range_distance_and_speed_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    always #2 clk = ~clk;

    logic [63:0]                 half_powers [1:30];
    logic [irds_pkg::DIST_W-1:0] cm_by_mean [0:ADC_TOP];

    logic [irds_pkg::COUNT_W-1:0]        period_cnt;
    logic [irds_pkg::DIST_W-1:0]         last_cm;
    logic signed [irds_pkg::SPEED_W-1:0] held_speed;
    logic [irds_pkg::DEADBAND_W-1:0]     dead_band;
    logic [irds_pkg::LIMIT_W-1:0]        speed_cap;
    logic [irds_pkg::THRESH_W-1:0]       update_thr;

    burst_t   item_queue [$];
    reading_t readings_due [$];
    burst_t   cur_item;
    burst_t   directed [24];
    reading_t due;
    logic     item_fire;
    bit       no_idle;
    int       outstanding;
    int       mismatches;
    int       results_checked;
    int       stall_cycles;
    int       level;
    int       p;
    int       i;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        int k;
        rem  = v;
        res  = '0;
        bitv = 64'd1 << 62;
        for (k = 0; k < 32; k++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] log2_fixed(input logic [31:0] x);
        logic [63:0] m;
        logic [63:0] acc;
        int msb;
        int k;
        if (x == '0) begin
            return '0;
        end
        msb = 0;
        for (k = 0; k < 32; k++) begin
            if (x[k]) begin
                msb = k;
            end
        end
        m   = (64'(x) << 30) >> msb;
        acc = 64'(msb) << 30;
        for (k = 29; k >= 0; k--) begin
            m = (m * m) >> 30;
            if (m >= (irds_pkg::Q30_ONE << 1)) begin
                m      = m >> 1;
                acc[k] = 1'b1;
            end
        end
        return acc;
    endfunction

    function automatic logic [irds_pkg::DIST_W-1:0] pow2_fixed(input longint z);
        logic [63:0] whole;
        logic [63:0] frac;
        logic [63:0] r;
        int k;
        if (z < 0) begin
            return '0;
        end
        whole = 64'(z) >> 30;
        frac  = 64'(z) & (irds_pkg::Q30_ONE - 64'd1);
        if (whole >= 64'd24) begin
            return irds_pkg::DIST_MAX;
        end
        r = irds_pkg::Q30_ONE;
        for (k = 1; k <= 30; k++) begin
            if (frac[30-k]) begin
                r = (r * half_powers[k]) >> 30;
            end
        end
        r = (r << whole) >> 30;
        return (r > 64'(irds_pkg::DIST_MAX)) ? irds_pkg::DIST_MAX
                                             : r[irds_pkg::DIST_W-1:0];
    endfunction

    function automatic logic [irds_pkg::DIST_W-1:0] cm_of_millivolts(input logic [31:0] mv);
        longint lref;
        longint z;
        if (mv == '0) begin
            return irds_pkg::DIST_MAX;
        end
        lref = longint'(log2_fixed(32'd1000));
        z = (lref - longint'(log2_fixed(mv))) * 12045 / 10000;
        z = z + longint'(log2_fixed(32'd27728)) - lref
              + (longint'(irds_pkg::DIST_FRAC_BITS) << 30);
        return pow2_fixed(z);
    endfunction

    function automatic reading_t advance_sensor(
        input logic [irds_pkg::SAMPLES_PER_ITEM-1:0][irds_pkg::ADC_BITS-1:0] adc
    );
        reading_t r;
        logic [irds_pkg::DIST_W-1:0] cm;
        logic [irds_pkg::DIST_W-1:0] mag;
        logic neg;
        int total;
        int k;
        total = 0;
        for (k = 0; k < irds_pkg::SAMPLES_PER_ITEM; k++) begin
            total += adc[k];
        end
        cm = cm_by_mean[total / irds_pkg::SAMPLES_PER_ITEM];
        r.updated = 1'b0;
        if (period_cnt > update_thr) begin
            neg = cm < last_cm;
            mag = neg ? last_cm - cm : cm - last_cm;
            if (mag < irds_pkg::DIST_W'(dead_band)) begin
                mag = '0;
            end
            if (mag > irds_pkg::DIST_W'(speed_cap)) begin
                mag = irds_pkg::DIST_W'(speed_cap);
            end
            held_speed = neg ? -$signed(irds_pkg::SPEED_W'(mag))
                             : $signed(irds_pkg::SPEED_W'(mag));
            last_cm    = cm;
            period_cnt = '0;
            r.updated  = 1'b1;
        end else begin
            period_cnt = period_cnt + 1'b1;
        end
        r.cm    = cm;
        r.speed = held_speed;
        return r;
    endfunction

    function automatic int clip_adc(input int v);
        return (v < 0) ? 0 : (v > ADC_TOP) ? ADC_TOP : v;
    endfunction

    function automatic burst_t row(input int a, input int b, input int c, input int d,
                                   input int e, input logic typed,
                                   input logic [irds_pkg::DIST_W-1:0] cm);
        burst_t s;
        s.adc[0]       = irds_pkg::ADC_BITS'(a);
        s.adc[1]       = irds_pkg::ADC_BITS'(b);
        s.adc[2]       = irds_pkg::ADC_BITS'(c);
        s.adc[3]       = irds_pkg::ADC_BITS'(d);
        s.adc[4]       = irds_pkg::ADC_BITS'(e);
        s.typed        = typed;
        s.want.cm      = cm;
        s.want.speed   = '0;
        s.want.updated = 1'b0;
        return s;
    endfunction

    function automatic burst_t next_burst();
        burst_t s;
        int pick;
        int k;
        pick    = $urandom_range(99);
        s.typed = 1'b0;
        s.want  = '0;
        if (pick < 60) begin
            if ($urandom_range(99) < 5) begin
                level = $urandom_range(ADC_TOP);
            end else begin
                level = clip_adc(level + $urandom_range(40) - 20);
            end
            for (k = 0; k < irds_pkg::SAMPLES_PER_ITEM; k++) begin
                s.adc[k] = irds_pkg::ADC_BITS'(clip_adc(level + $urandom_range(6) - 3));
            end
        end else if (pick < 85) begin
            for (k = 0; k < irds_pkg::SAMPLES_PER_ITEM; k++) begin
                s.adc[k] = irds_pkg::ADC_BITS'($urandom_range(ADC_TOP));
            end
        end else if (pick < 93) begin
            for (k = 0; k < irds_pkg::SAMPLES_PER_ITEM; k++) begin
                s.adc[k] = $urandom_range(1) ? irds_pkg::ADC_BITS'(ADC_TOP) : '0;
            end
        end else begin
            for (k = 0; k < irds_pkg::SAMPLES_PER_ITEM; k++) begin
                s.adc[k] = irds_pkg::ADC_BITS'($urandom_range(3));
            end
        end
        return s;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH result %0d: %s", results_checked, msg);
        mismatches++;
    endtask

    task automatic write_reg(input logic [irds_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [irds_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do begin
            @(posedge clk);
        end while (!(cfg_if.valid && cfg_if.ready));
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic feed(input int n);
        @(posedge clk);
        repeat (n) begin
            item_queue.push_back(next_burst());
            outstanding++;
        end
        while (outstanding != 0) begin
            @(negedge clk);
        end
    endtask

    // hold the current item until its transfer, then advance or idle
    always @(negedge clk) begin
        if (!item_if.valid || item_fire) begin
            if (item_queue.size() != 0 && (no_idle || $urandom_range(99) >= 37)) begin
                cur_item = item_queue.pop_front();
                item_if.valid    <= 1'b1;
                item_if.sample_0 <= cur_item.adc[0];
                item_if.sample_1 <= cur_item.adc[1];
                item_if.sample_2 <= cur_item.adc[2];
                item_if.sample_3 <= cur_item.adc[3];
                item_if.sample_4 <= cur_item.adc[4];
            end else begin
                item_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        result_if.ready <= no_idle || ($urandom_range(99) >= 37);
    end

    always @(posedge clk) begin
        item_fire <= item_if.valid && item_if.ready;
        if (rst_n) begin
            if (result_if.valid && result_if.ready) begin
                if (readings_due.size() == 0) begin
                    flag_mismatch($sformatf("nothing due, got distance %h speed %0d",
                                            result_if.distance, result_if.speed));
                end else begin
                    due = readings_due.pop_front();
                    outstanding--;
                    if (result_if.distance !== due.cm) begin
                        flag_mismatch($sformatf("distance %h, want %h",
                                                result_if.distance, due.cm));
                    end
                    if (result_if.speed !== due.speed) begin
                        flag_mismatch($sformatf("speed %0d, want %0d",
                                                result_if.speed, due.speed));
                    end
                    if (result_if.speed_updated !== due.updated) begin
                        flag_mismatch($sformatf("speed_updated %b, want %b",
                                                result_if.speed_updated, due.updated));
                    end
                end
                results_checked++;
            end
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    irds_pkg::CFG_DEADBAND:  dead_band  = cfg_if.data;
                    irds_pkg::CFG_LIMIT:     speed_cap  = cfg_if.data;
                    irds_pkg::CFG_THRESHOLD: update_thr = cfg_if.data[irds_pkg::THRESH_W-1:0];
                    default: ;
                endcase
            end
            if (item_if.valid && item_if.ready) begin
                due = advance_sensor(cur_item.adc);
                if (cur_item.typed) begin
                    due = cur_item.want;
                end
                readings_due.push_back(due);
            end
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)
                    || (cfg_if.valid && cfg_if.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("ir_range_distance_and_speed_top verification failed");
                $finish;
            end
        end
    end

    initial begin
        rst_n            = 1'b0;
        item_if.valid    = 1'b0;
        item_if.sample_0 = '0;
        item_if.sample_1 = '0;
        item_if.sample_2 = '0;
        item_if.sample_3 = '0;
        item_if.sample_4 = '0;
        result_if.ready  = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = irds_pkg::CFG_DEADBAND;
        cfg_if.data      = '0;
        item_fire        = 1'b0;
        no_idle          = 1'b0;
        outstanding      = 0;
        mismatches       = 0;
        results_checked  = 0;
        stall_cycles     = 0;
        level            = ADC_TOP / 2;
        period_cnt       = '0;
        last_cm          = '0;
        held_speed       = '0;
        dead_band        = irds_pkg::DEADBAND_RESET;
        speed_cap        = irds_pkg::LIMIT_RESET;
        update_thr       = irds_pkg::THRESHOLD_RESET;

        half_powers[1] = int_sqrt((irds_pkg::Q30_ONE << 1) << 30);
        for (i = 2; i <= 30; i++) begin
            half_powers[i] = int_sqrt(half_powers[i-1] << 30);
        end
        for (i = 0; i <= ADC_TOP; i++) begin
            cm_by_mean[i] = cm_of_millivolts(32'(i * 5000 / ADC_TOP));
        end

        // speed stays zero until the twelfth item after reset
        directed[0]  = row(0, 0, 0, 0, 0, 1'b1, irds_pkg::DIST_MAX);
        directed[1]  = row(1023, 1023, 1023, 1023, 1023, 1'b0, '0);
        directed[2]  = row(4, 0, 0, 0, 0, 1'b1, irds_pkg::DIST_MAX);
        directed[3]  = row(1, 1, 1, 1, 0, 1'b1, irds_pkg::DIST_MAX);
        directed[4]  = row(5, 0, 0, 0, 0, 1'b0, '0);
        directed[5]  = row(341, 341, 341, 341, 341, 1'b0, '0);
        directed[6]  = row(682, 682, 682, 682, 682, 1'b0, '0);
        directed[7]  = row(1023, 0, 0, 0, 0, 1'b0, '0);
        directed[8]  = row(0, 1023, 0, 0, 0, 1'b0, '0);
        directed[9]  = row(0, 0, 1023, 0, 0, 1'b0, '0);
        directed[10] = row(0, 0, 0, 1023, 0, 1'b0, '0);
        directed[11] = row(0, 0, 0, 0, 1023, 1'b0, '0);
        for (i = 12; i < 23; i++) begin
            directed[i] = row(512, 512, 512, 512, 512, 1'b0, '0);
        end
        directed[23] = row(204, 204, 205, 205, 204, 1'b0, '0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        foreach (directed[i]) begin
            item_queue.push_back(directed[i]);
            outstanding++;
        end
        feed(0);
        feed(150);

        write_reg(irds_pkg::CFG_THRESHOLD, '0);
        write_reg(irds_pkg::CFG_DEADBAND, '0);
        write_reg(CFG_SPARE, irds_pkg::CFG_DATA_W'($urandom_range(2047)));
        feed(150);

        // threshold at its top: the counter wraps and speed never refreshes
        write_reg(irds_pkg::CFG_THRESHOLD, 11'd255);
        write_reg(irds_pkg::CFG_DEADBAND, 11'd1280);
        write_reg(irds_pkg::CFG_LIMIT, '0);
        feed(226);

        write_reg(irds_pkg::CFG_THRESHOLD, 11'd1);
        write_reg(irds_pkg::CFG_LIMIT, 11'd1280);
        feed(100);

        write_reg(irds_pkg::CFG_THRESHOLD, 11'd2);
        write_reg(irds_pkg::CFG_DEADBAND, '0);
        write_reg(irds_pkg::CFG_LIMIT, 11'd64);
        feed(100);

        for (p = 0; p < 4; p++) begin
            write_reg(irds_pkg::CFG_DEADBAND, irds_pkg::CFG_DATA_W'($urandom_range(1280)));
            write_reg(irds_pkg::CFG_LIMIT, irds_pkg::CFG_DATA_W'($urandom_range(1280)));
            write_reg(irds_pkg::CFG_THRESHOLD, irds_pkg::CFG_DATA_W'($urandom_range(12)));
            @(posedge clk);
            no_idle = (p == 1);
            feed(100);
        end
        no_idle = 1'b0;

        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("ir_range_distance_and_speed_top verification clean");
        end else begin
            $display("ir_range_distance_and_speed_top verification failed");
        end
        $finish;
    end

endmodule
